// ----- design/fixed_point_q24_8_alu_assert.svh -----
// Assertion macros shared by the fixed-point ALU RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// Antecedent implies consequent in the same cycle, checked out of reset.
`define FPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant, checked out of reset.
`define FPA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

`endif

// ----- design/fpa_pkg.sv -----
// Shared types, constants and helper functions of the fixed-point ALU.
// Depends on nothing; used by the top level and the input, cell and output stages.
package fpa_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 8;
    localparam int W          = DATA_WIDTH;
    localparam int QW         = DATA_WIDTH + FRAC_BITS;  // quotient bits, one cell each
    localparam int MW         = 2 * DATA_WIDTH + 1;      // wide magnitude before saturation

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
        OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_FROM_INT, OP_TO_INT
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    localparam logic [W-1:0]  DMAX      = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  DMIN      = {1'b1, {(W-1){1'b0}}};
    localparam logic [MW-1:0] MAG_MAXP  = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [MW-1:0] MAG_MINN  = {{(MW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [MW-1:0] MUL_HALF  = MW'(1) << (FRAC_BITS - 1);

    // One transaction in flight through the chain.
    typedef struct packed {
        logic          vld;
        t_op           op;
        logic          a_neg;
        logic          neg;     // sign of a mul/div result
        logic          div0;
        logic [W-1:0]  res;     // result of the ops finished in the input stage
        logic          cmp;
        t_status       st;
        logic [2*W-1:0] prod;   // magnitude product
        logic [QW-1:0] num;     // dividend bits, shifted out MSB first
        logic [W-1:0]  mb;      // divisor magnitude
        logic [W-1:0]  rem;
        logic [QW-1:0] quo;
    } t_tok;

    typedef struct packed {
        logic [W-1:0] val;
        logic         ovf;
    } t_sat;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    // Encode sign and magnitude, saturating when it does not fit.
    function automatic t_sat sat_pack(input logic neg, input logic [MW-1:0] m);
        t_sat s;
        s.ovf = 1'b0;
        if (!neg) begin
            if (m > MAG_MAXP) begin
                s.val = DMAX;
                s.ovf = 1'b1;
            end else begin
                s.val = m[W-1:0];
            end
        end else begin
            if (m > MAG_MINN) begin
                s.val = DMIN;
                s.ovf = 1'b1;
            end else begin
                s.val = ~m[W-1:0] + W'(1);
            end
        end
        return s;
    endfunction

endpackage

// ----- design/fpa_ifs.sv -----
// Valid/ready channel interfaces of the fixed-point ALU.
// Depends on nothing; used by the top level.
interface fpa_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    modport source (output valid, opcode, operand_a, operand_b, input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
    modport source (output valid, result_value, compare_true, status, input ready);
    modport sink   (input valid, result_value, compare_true, status, output ready);
endinterface

// ----- design/fixed_point_q24_8_alu.sv -----
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on fpa_pkg, fpa_ifs, fpa_front, fpa_div_cell, fpa_back and the assert header.
//
// Usage:
//   i_in  : input transaction (opcode, operand_a, operand_b), taken when
//           valid and ready are both high at a rising edge of i_clk.
//   o_out : result transaction (result_value, compare_true, status).
// Every opcode travels the same path: an input stage, a row of 40 division
// cells (one quotient bit per cell, DATA_WIDTH + FRAC_BITS of them) and an
// output register. All operations take equally long, so results leave in
// order. Throughput is one transaction per cycle unless the receiver stalls;
// the length of the cell row sets the latency.
// The whole row advances together whenever the output register is empty or
// being taken; when the receiver stalls with a result held, the row freezes
// and i_in.ready drops in the same cycle.
// Reset (i_rst_n low, synchronous) clears every stage's valid bit; no item
// survives it and no clearing pass follows.
`include "fixed_point_q24_8_alu_assert.svh"

module fixed_point_q24_8_alu import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);
    t_tok         w_tok [QW+1];
    logic         adv;
    logic [W-1:0] res;

    // Advance the whole chain unless a held result is being stalled.
    assign adv        = !o_out.valid || o_out.ready;
    assign i_in.ready = adv;

    fpa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_vld    (i_in.valid),
        .i_opcode (i_in.opcode),
        .i_a      (W'(i_in.operand_a)),
        .i_b      (W'(i_in.operand_b)),
        .o_tok    (w_tok[0])
    );

    // One cell per quotient bit, MSB first.
    for (genvar k = 0; k < QW; k++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_tok   (w_tok[QW]),
        .o_vld   (o_out.valid),
        .o_res   (res),
        .o_cmp   (o_out.compare_true),
        .o_st    (o_out.status)
    );

    assign o_out.result_value = $signed(res);

    `FPA_ASSERT_IMPLY(a_cmp_clean, i_clk, i_rst_n, o_out.valid && o_out.compare_true, (res == '0) && (o_out.status == ST_OK), "compare result carries value or status")
    `FPA_ASSERT_IMPLY(a_sat_value, i_clk, i_rst_n, o_out.valid && (o_out.status != ST_OK), (res == DMAX) || (res == DMIN), "flagged result is not saturated")
    `FPA_ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, o_out.valid, o_out.status != 2'd3, "undefined status code")
    `FPA_ASSERT_IMPLY(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, ##1 (o_out.valid && $stable(res)), "stalled result changed")
endmodule

// ----- design/fpa_front.sv -----
// Input stage: decode, the ops finished here, magnitude product, divider setup.
// Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  logic [3:0]   i_opcode,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output t_tok         o_tok
);
    t_tok          r_tok;
    t_tok          n_tok;
    t_op           op;
    logic          sa, sb, is_sub, ovf, gt, lt, eq;
    logic [W-1:0]  rhs, sum, ma, mb, ti;
    t_sat          fi;

    always_comb begin
        op     = t_op'(i_opcode);
        sa     = i_a[W-1];
        sb     = i_b[W-1];
        ma     = mag_of(i_a);
        mb     = mag_of(i_b);
        is_sub = (op == OP_SUB) || (op == OP_DEC);
        rhs    = ((op == OP_INC) || (op == OP_DEC)) ? W'(1) : i_b;
        sum    = is_sub ? (i_a - rhs) : (i_a + rhs);
        ovf    = is_sub ? ((sa != rhs[W-1]) && (sum[W-1] != sa))
                        : ((sa == rhs[W-1]) && (sum[W-1] != sa));
        gt     = $signed(i_a) > $signed(i_b);
        lt     = $signed(i_a) < $signed(i_b);
        eq     = (i_a == i_b);
        fi     = sat_pack(sa, MW'(ma) << FRAC_BITS);
        ti     = ma >> FRAC_BITS;
        if (sa) begin
            ti = ~ti + W'(1);
        end

        n_tok       = '0;
        n_tok.vld   = i_vld;
        n_tok.op    = op;
        n_tok.a_neg = sa;
        n_tok.neg   = sa ^ sb;
        n_tok.div0  = (mb == '0);
        n_tok.prod  = (2*W)'(ma) * (2*W)'(mb);
        n_tok.num   = {ma, {FRAC_BITS{1'b0}}};
        n_tok.mb    = mb;
        n_tok.st    = ST_OK;
        case (op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                n_tok.res = ovf ? (sa ? DMIN : DMAX) : sum;
                n_tok.st  = ovf ? ST_OVF : ST_OK;
            end
            OP_GT: n_tok.cmp = gt;
            OP_LT: n_tok.cmp = lt;
            OP_GE: n_tok.cmp = !lt;
            OP_LE: n_tok.cmp = !gt;
            OP_EQ: n_tok.cmp = eq;
            OP_NE: n_tok.cmp = !eq;
            OP_MIN: n_tok.res = lt ? i_a : i_b;
            OP_MAX: n_tok.res = gt ? i_a : i_b;
            OP_FROM_INT: begin
                n_tok.res = fi.val;
                n_tok.st  = fi.ovf ? ST_OVF : ST_OK;
            end
            OP_TO_INT: n_tok.res = ti;
            default: n_tok.res = '0;  // mul and div finish in the output stage
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
endmodule

// ----- design/fpa_div_cell.sv -----
// One restoring-division cell: retire one quotient bit, pass the rest on.
// Depends on fpa_pkg.
module fpa_div_cell import fpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_tok i_tok,
    output t_tok o_tok
);
    t_tok        r_tok;
    t_tok        n_tok;
    logic [W:0]  part;
    logic        take;

    always_comb begin
        part  = {i_tok.rem, i_tok.num[QW-1]};
        take  = (part >= {1'b0, i_tok.mb});
        n_tok = i_tok;
        n_tok.num = {i_tok.num[QW-2:0], 1'b0};
        n_tok.rem = take ? W'(part - {1'b0, i_tok.mb}) : part[W-1:0];
        n_tok.quo = {i_tok.quo[QW-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
endmodule

// ----- design/fpa_back.sv -----
// Output stage: round and saturate mul/div, select result, hold output register.
// Depends on fpa_pkg.
module fpa_back import fpa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  t_tok         i_tok,
    output logic         o_vld,
    output logic [W-1:0] o_res,
    output logic         o_cmp,
    output logic [1:0]   o_st
);
    logic          r_vld;
    logic [W-1:0]  r_res;
    logic          r_cmp;
    t_status       r_st;
    logic [W-1:0]  n_res;
    t_status       n_st;
    logic [MW-1:0] mul_mag, div_mag;
    logic          rnd;
    t_sat          ms, ds;

    always_comb begin
        mul_mag = ({1'b0, i_tok.prod} + MUL_HALF) >> FRAC_BITS;
        rnd     = ({i_tok.rem, 1'b0} >= {1'b0, i_tok.mb});
        div_mag = MW'(i_tok.quo) + MW'(rnd);
        ms      = sat_pack(i_tok.neg, mul_mag);
        ds      = sat_pack(i_tok.neg, div_mag);
        n_res   = i_tok.res;
        n_st    = i_tok.st;
        case (i_tok.op)
            OP_MUL: begin
                n_res = ms.val;
                n_st  = ms.ovf ? ST_OVF : ST_OK;
            end
            OP_DIV: begin
                if (i_tok.div0) begin
                    n_res = i_tok.a_neg ? DMIN : DMAX;
                    n_st  = ST_DIV0;
                end else begin
                    n_res = ds.val;
                    n_st  = ds.ovf ? ST_OVF : ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_tok.vld;
            r_res <= n_res;
            r_cmp <= i_tok.cmp;
            r_st  <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;
    assign o_cmp = r_cmp;
    assign o_st  = r_st;
endmodule
